@@ sv/assert_macros.svh @@
// Assertion helpers used by the pin bank RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define GB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define GB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/gbei_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbei_pkg
// Types, codes and helpers of the pin bank with edge interrupts.
// ----------------------------------------------------------------------------
package gbei_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned LEVEL_W   = 30;
  localparam int unsigned GRP_IDX_W = 2;
  localparam int unsigned SEL_W     = 4;
  localparam int unsigned MAX_GRPS  = 4;
  localparam int unsigned GRP_PINS  = 8;
  localparam int unsigned BITS_PER_PIN = 4;
  localparam int unsigned EVENT_BIT = 3;

  // Beat kinds
  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_SAMPLE = 2'd2
  } kind_t;

  // Register map
  typedef enum logic [SEL_W-1:0] {
    REG_OUT     = 4'd0,
    REG_OUT_SET = 4'd1,
    REG_OUT_CLR = 4'd2,
    REG_OUT_XOR = 4'd3,
    REG_OE      = 4'd4,
    REG_OE_SET  = 4'd5,
    REG_OE_CLR  = 4'd6,
    REG_INTR    = 4'd7,
    REG_INTE    = 4'd8,
    REG_INTS    = 4'd9,
    REG_IN      = 4'd10
  } reg_sel_t;

  // Spread eight pin events of a group to bit 4*i+3 of a register word.
  function automatic logic [DATA_W-1:0] spread_events(logic [GRP_PINS-1:0] ev);
    logic [DATA_W-1:0] w;
    w = '0;
    for (int i = 0; i < GRP_PINS; i++) begin
      w[BITS_PER_PIN*i + EVENT_BIT] = ev[i];
    end
    return w;
  endfunction

endpackage

@@ sv/gpio_bank_with_edge_interrupts_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_bank_with_edge_interrupts_unit
// Pin bank registers: output and output-enable words with set, clear and
// toggle aliases, rising-edge event latching, grouped interrupt registers.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (in_*): each beat is a bus read, a bus write or a pin sample,
//   chosen by in_tuser. in_tdata carries the register select, the interrupt
//   group, the write word and the sampled pin levels.
//   Result stream (out_*): exactly one beat per input beat, in order, with
//   the read word (zero for writes and samples), the output and output-enable
//   words after the access, and the irq flag after the access.
//   Pipeline: an accepted beat is registered in the input register, processed,
//   and its result is loaded into the result register once that slot is free.
//   Throughput: one beat per cycle while out_tready is high; the whole access is one pass of logic
//   between the input register and the result register.
//   Stall: when out_tready is low the result holds, the input register fills
//   and in_tready then drops; nothing is lost or repeated.
//   Reset: rst_n low clears both pipeline valids, the output and enable
//   words, the last sampled levels, pending events and all group enables.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gpio_bank_with_edge_interrupts_unit #(
  parameter int unsigned NUM_PINS   = 30,
  parameter int unsigned NUM_GROUPS = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // [3:0] reg_select, [5:4] group, [37:6] write_data, [67:38] pin_levels
  input  logic [71:0]                in_tdata,
  // [1:0] kind
  input  logic [1:0]                 in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [31:0] read_data, [61:32] out_levels, [91:62] out_enables, [92] irq
  output logic [95:0]                out_tdata
);
  import gbei_pkg::*;

  localparam int unsigned GRP_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  // Input register
  logic                   s1_valid_r;
  logic [1:0]             s1_kind_r;
  logic [SEL_W-1:0]       s1_sel_r;
  logic [GRP_IDX_W-1:0]   s1_grp_r;
  logic [DATA_W-1:0]      s1_data_r;
  logic [LEVEL_W-1:0]     s1_lvl_r;

  // Result register
  logic                   out_valid_r;
  logic [DATA_W-1:0]      rd_r;
  logic [LEVEL_W-1:0]     lvl_out_r;
  logic [LEVEL_W-1:0]     oe_out_r;
  logic                   irq_r;

  // Bank state
  logic [NUM_PINS-1:0]    out_word_r, out_word_nxt;
  logic [NUM_PINS-1:0]    oe_word_r, oe_word_nxt;
  logic [NUM_PINS-1:0]    last_lvl_r, last_lvl_nxt;
  logic [NUM_PINS-1:0]    events_r, events_nxt;
  logic [DATA_W-1:0]      irq_ena_r [NUM_GROUPS];
  logic [DATA_W-1:0]      irq_ena_nxt [NUM_GROUPS];

  logic                   s1_adv;
  logic                   grp_present;
  logic [GRP_W-1:0]       grp_idx;
  logic [NUM_PINS-1:0]    pdata;
  logic [NUM_PINS-1:0]    levels;
  logic [DATA_W-1:0]      lvl32;
  logic [DATA_W-1:0]      ev_cur32, ev_nxt32;
  logic [DATA_W-1:0]      clr32;
  logic [DATA_W-1:0]      gev_cur [MAX_GRPS];
  logic [DATA_W-1:0]      gev_nxt [MAX_GRPS];
  logic [DATA_W-1:0]      grp_ena;
  logic [DATA_W-1:0]      rd_nxt;
  logic                   irq_nxt;
  logic                   irq_cur;

  // Handshake: advance the input register when the result slot frees up
  assign s1_adv     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, irq_r, oe_out_r, lvl_out_r, rd_r};

  // Operand decode
  assign grp_present = 32'(s1_grp_r) < NUM_GROUPS;
  assign grp_idx     = s1_grp_r[GRP_W-1:0];
  assign pdata       = s1_data_r[NUM_PINS-1:0];
  assign lvl32       = 32'(s1_lvl_r);
  assign levels      = lvl32[NUM_PINS-1:0];
  assign ev_cur32    = 32'(events_r);
  assign grp_ena     = grp_present ? irq_ena_r[grp_idx] : '0;

  // Clear mask: pin 8g+i drops when bit 4i+3 of the written word is set
  always_comb begin
    clr32 = '0;
    for (int p = 0; p < DATA_W; p++) begin
      clr32[p] = (p / GRP_PINS == 32'(s1_grp_r)) &&
                 s1_data_r[BITS_PER_PIN*(p % GRP_PINS) + EVENT_BIT];
    end
  end

  // Group views of the current events
  always_comb begin
    for (int k = 0; k < MAX_GRPS; k++) begin
      gev_cur[k] = spread_events(ev_cur32[GRP_PINS*k +: GRP_PINS]);
    end
  end

  // Next state of the bank and the read word
  always_comb begin
    out_word_nxt = out_word_r;
    oe_word_nxt  = oe_word_r;
    last_lvl_nxt = last_lvl_r;
    events_nxt   = events_r;
    for (int k = 0; k < NUM_GROUPS; k++) begin
      irq_ena_nxt[k] = irq_ena_r[k];
    end
    rd_nxt = '0;
    case (s1_kind_r)
      KIND_READ: begin
        case (s1_sel_r)
          REG_OUT:  rd_nxt = 32'(out_word_r);
          REG_OE:   rd_nxt = 32'(oe_word_r);
          REG_INTR: rd_nxt = grp_present ? gev_cur[s1_grp_r] : '0;
          REG_INTE: rd_nxt = grp_ena;
          REG_INTS: rd_nxt = grp_present ? (gev_cur[s1_grp_r] & grp_ena) : '0;
          REG_IN:   rd_nxt = 32'(last_lvl_r);
          default:  rd_nxt = '0;
        endcase
      end
      KIND_WRITE: begin
        case (s1_sel_r)
          REG_OUT:     out_word_nxt = pdata;
          REG_OUT_SET: out_word_nxt = out_word_r | pdata;
          REG_OUT_CLR: out_word_nxt = out_word_r & ~pdata;
          REG_OUT_XOR: out_word_nxt = out_word_r ^ pdata;
          REG_OE:      oe_word_nxt  = pdata;
          REG_OE_SET:  oe_word_nxt  = oe_word_r | pdata;
          REG_OE_CLR:  oe_word_nxt  = oe_word_r & ~pdata;
          REG_INTR: begin
            if (grp_present) begin
              events_nxt = events_r & ~clr32[NUM_PINS-1:0];
            end
          end
          REG_INTE: begin
            if (grp_present) begin
              irq_ena_nxt[grp_idx] = s1_data_r;
            end
          end
          default: ;
        endcase
      end
      KIND_SAMPLE: begin
        events_nxt   = events_r | (levels & ~last_lvl_r);
        last_lvl_nxt = levels;
      end
      default: ;
    endcase
  end

  // Interrupt line after the access, and for the current state
  assign ev_nxt32 = 32'(events_nxt);
  always_comb begin
    irq_nxt = 1'b0;
    irq_cur = 1'b0;
    for (int k = 0; k < MAX_GRPS; k++) begin
      gev_nxt[k] = spread_events(ev_nxt32[GRP_PINS*k +: GRP_PINS]);
    end
    for (int k = 0; k < NUM_GROUPS; k++) begin
      irq_nxt = irq_nxt | (|(gev_nxt[k] & irq_ena_nxt[k]));
      irq_cur = irq_cur | (|(gev_cur[k] & irq_ena_r[k]));
    end
  end

  // Capture an input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s1_kind_r <= in_tuser;
      s1_sel_r  <= in_tdata[3:0];
      s1_grp_r  <= in_tdata[5:4];
      s1_data_r <= in_tdata[37:6];
      s1_lvl_r  <= in_tdata[67:38];
    end
  end

  // Commit state and load the result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_word_r  <= '0;
      oe_word_r   <= '0;
      last_lvl_r  <= '0;
      events_r    <= '0;
      for (int k = 0; k < NUM_GROUPS; k++) begin
        irq_ena_r[k] <= '0;
      end
    end else begin
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        out_word_r  <= out_word_nxt;
        oe_word_r   <= oe_word_nxt;
        last_lvl_r  <= last_lvl_nxt;
        events_r    <= events_nxt;
        for (int k = 0; k < NUM_GROUPS; k++) begin
          irq_ena_r[k] <= irq_ena_nxt[k];
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (s1_adv) begin
      rd_r      <= rd_nxt;
      lvl_out_r <= LEVEL_W'(out_word_nxt);
      oe_out_r  <= LEVEL_W'(oe_word_nxt);
      irq_r     <= irq_nxt;
    end
  end

  // Assertions
  `GB_ASSERT(a_irq_matches_state, !out_valid_r || (irq_r == irq_cur), "irq beat disagrees with state")
  `GB_ASSERT_NEXT(a_events_hold, !(s1_adv && ((s1_kind_r == KIND_SAMPLE) || ((s1_kind_r == KIND_WRITE) && (s1_sel_r == REG_INTR)))), $stable(events_r), "events changed without sample or clear")
  `GB_ASSERT_NEXT(a_levels_hold, !(s1_adv && (s1_kind_r == KIND_SAMPLE)), $stable(last_lvl_r), "sampled levels changed without a sample")

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pin bank with rising-edge interrupts. A short
// table of directed beats covers every register, the aliases, write-one-to-
// clear and the ignored accesses. Random reads, writes and pin samples
// follow. A local model of the bank predicts each result beat that the
// table does not give; every beat is compared field by field. The sender
// works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;
  import gbei_pkg::*;

  localparam int unsigned PINS         = LEVEL_W;
  localparam int unsigned GROUPS       = MAX_GRPS;
  localparam int          RANDOM_BEATS = 500;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          TAIL_CYCLES  = 8;

  // Codes outside the defined kinds and register map
  localparam logic [1:0]       KIND_UNUSED   = 2'd3;
  localparam logic [SEL_W-1:0] REG_UNUSED_LO = 4'd11;
  localparam logic [SEL_W-1:0] REG_UNUSED_HI = 4'd15;

  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
  localparam logic [29:0] ALL_PINS  = 30'h3FFF_FFFF;

  typedef struct packed {
    logic [31:0] rd;
    logic [29:0] levels;
    logic [29:0] enables;
    logic        irq;
  } pin_result_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [SEL_W-1:0] sel;
    logic [1:0]       grp;
    logic [31:0]      wdata;
    logic [29:0]      levels;
    logic             typed;
    pin_result_t      res;
  } stim_row_t;

  localparam int DIR_ROWS = 25;

  // Directed beats; rows with typed set carry their result, the rest are
  // checked against the bank model
  localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
    '{KIND_READ,   REG_OUT,       2'd0, 32'h0,       30'h0,    1'b1, '{32'h0, 30'h0, 30'h0, 1'b0}},
    '{KIND_READ,   REG_IN,        2'd0, 32'h0,       30'h0,    1'b1, '{32'h0, 30'h0, 30'h0, 1'b0}},
    '{KIND_WRITE,  REG_OUT,       2'd0, ALL_ONES,    30'h0,    1'b1,
      '{32'h0, ALL_PINS, 30'h0, 1'b0}},
    '{KIND_WRITE,  REG_OUT_CLR,   2'd0, ALL_ONES,    30'h0,    1'b1, '{32'h0, 30'h0, 30'h0, 1'b0}},
    '{KIND_WRITE,  REG_OUT_SET,   2'd0, 32'hAAAAAAAA, 30'h0,   1'b0, '0},
    '{KIND_WRITE,  REG_OUT_XOR,   2'd0, ALL_ONES,    30'h0,    1'b0, '0},
    '{KIND_READ,   REG_OUT_SET,   2'd0, 32'h0,       30'h0,    1'b0, '0},
    '{KIND_WRITE,  REG_OE,        2'd0, ALL_ONES,    30'h0,    1'b0, '0},
    '{KIND_WRITE,  REG_OE_CLR,    2'd0, 32'h55555555, 30'h0,   1'b0, '0},
    '{KIND_WRITE,  REG_OE_SET,    2'd0, 32'h00000001, 30'h0,   1'b0, '0},
    '{KIND_READ,   REG_OE,        2'd0, 32'h0,       30'h0,    1'b0, '0},
    '{KIND_WRITE,  REG_INTE,      2'd0, ALL_ONES,    30'h0,    1'b0, '0},
    '{KIND_WRITE,  REG_INTE,      2'd3, 32'h88888888, 30'h0,   1'b0, '0},
    '{KIND_SAMPLE, REG_OUT,       2'd0, 32'h0,       ALL_PINS, 1'b0, '0},
    '{KIND_READ,   REG_INTR,      2'd3, 32'h0,       30'h0,    1'b0, '0},
    '{KIND_READ,   REG_INTS,      2'd0, 32'h0,       30'h0,    1'b0, '0},
    '{KIND_WRITE,  REG_INTR,      2'd0, ALL_ONES,    30'h0,    1'b0, '0},
    '{KIND_WRITE,  REG_INTS,      2'd1, ALL_ONES,    30'h0,    1'b0, '0},
    '{KIND_WRITE,  REG_IN,        2'd0, ALL_ONES,    30'h0,    1'b0, '0},
    '{KIND_READ,   REG_INTE,      2'd3, 32'h0,       30'h0,    1'b0, '0},
    '{KIND_SAMPLE, REG_OUT,       2'd0, 32'h0,       30'h0,    1'b0, '0},
    '{KIND_UNUSED, REG_OUT,       2'd0, ALL_ONES,    ALL_PINS, 1'b0, '0},
    '{KIND_READ,   REG_UNUSED_HI, 2'd2, 32'h0,       30'h0,    1'b0, '0},
    '{KIND_WRITE,  REG_UNUSED_LO, 2'd1, ALL_ONES,    30'h0,    1'b0, '0},
    '{KIND_WRITE,  REG_INTR,      2'd3, ALL_ONES,    30'h0,    1'b0, '0}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;

  gpio_bank_with_edge_interrupts_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bank model state
  logic [29:0] drive_word;
  logic [29:0] oe_word;
  logic [29:0] last_levels;
  logic [29:0] rise_events;
  logic [31:0] group_enables [GROUPS];

  pin_result_t expected_results [$];
  int err_count   = 0;
  int n_checked   = 0;
  int n_reads     = 0;
  int n_writes    = 0;
  int n_samples   = 0;
  int n_irq_high  = 0;
  int cycle_count = 0;
  int burst_left  = 0;
  logic [29:0] prev_levels = '0;

  // Place the pending events of one group at bit 4*i+3
  function automatic logic [31:0] group_events(input logic [1:0] grp);
    logic [31:0] w;
    int pin;
    w = '0;
    for (int i = 0; i < GRP_PINS; i++) begin
      pin = int'(grp) * GRP_PINS + i;
      if (pin < PINS && rise_events[pin]) w[BITS_PER_PIN*i + EVENT_BIT] = 1'b1;
    end
    return w;
  endfunction

  // Advance the bank model by one beat and return its result
  function automatic pin_result_t apply_access(input logic [1:0] kind,
                                               input logic [SEL_W-1:0] sel,
                                               input logic [1:0] grp,
                                               input logic [31:0] wdata,
                                               input logic [29:0] levels);
    pin_result_t r;
    logic [29:0] pdata;
    int pin;
    r = '0;
    pdata = wdata[29:0];
    if (kind == KIND_READ) begin
      case (sel)
        REG_OUT:  r.rd = {2'b00, drive_word};
        REG_OE:   r.rd = {2'b00, oe_word};
        REG_INTR: r.rd = group_events(grp);
        REG_INTE: r.rd = group_enables[grp];
        REG_INTS: r.rd = group_events(grp) & group_enables[grp];
        REG_IN:   r.rd = {2'b00, last_levels};
        default: ;
      endcase
    end else if (kind == KIND_WRITE) begin
      case (sel)
        REG_OUT:     drive_word = pdata;
        REG_OUT_SET: drive_word = drive_word | pdata;
        REG_OUT_CLR: drive_word = drive_word & ~pdata;
        REG_OUT_XOR: drive_word = drive_word ^ pdata;
        REG_OE:      oe_word = pdata;
        REG_OE_SET:  oe_word = oe_word | pdata;
        REG_OE_CLR:  oe_word = oe_word & ~pdata;
        REG_INTR: begin
          for (int i = 0; i < GRP_PINS; i++) begin
            pin = int'(grp) * GRP_PINS + i;
            if (pin < PINS && wdata[BITS_PER_PIN*i + EVENT_BIT]) rise_events[pin] = 1'b0;
          end
        end
        REG_INTE: group_enables[grp] = wdata;
        default: ;
      endcase
    end else if (kind == KIND_SAMPLE) begin
      rise_events = rise_events | (levels & ~last_levels);
      last_levels = levels;
    end
    r.levels  = drive_word;
    r.enables = oe_word;
    for (int g = 0; g < GROUPS; g++) begin
      if ((group_events(2'(g)) & group_enables[g]) != '0) r.irq = 1'b1;
    end
    return r;
  endfunction

  // Present one beat, with a random gap ahead of each burst, and queue its result
  task automatic send_beat(input logic [1:0] kind, input logic [SEL_W-1:0] sel,
                           input logic [1:0] grp, input logic [31:0] wdata,
                           input logic [29:0] levels, input logic typed,
                           input pin_result_t typed_res);
    int gap;
    pin_result_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    burst_left = burst_left - 1;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0000, levels, wdata, grp, sel};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = apply_access(kind, sel, grp, wdata, levels);
    expected_results.push_back(typed ? typed_res : r);
    if (kind == KIND_READ) n_reads++;
    else if (kind == KIND_WRITE) n_writes++;
    else if (kind == KIND_SAMPLE) n_samples++;
  endtask

  // Receiver stall pattern: ready, random, sparse and periodic phases
  always @(posedge clk) begin
    case (cycle_count[7:6])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= 1'($urandom_range(0, 1));
      2'd2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= cycle_count[1];
    endcase
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    pin_result_t want;
    pin_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[31:0], out_tdata[61:32], out_tdata[91:62], out_tdata[92]};
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: %h", out_tdata);
        err_count++;
      end else begin
        want = expected_results.pop_front();
        n_checked++;
        if (got.irq) n_irq_high++;
        if (got.rd !== want.rd) begin
          $error("read_data expected %h actual %h", want.rd, got.rd);
          err_count++;
        end
        if (got.levels !== want.levels) begin
          $error("out_levels expected %h actual %h", want.levels, got.levels);
          err_count++;
        end
        if (got.enables !== want.enables) begin
          $error("out_enables expected %h actual %h", want.enables, got.enables);
          err_count++;
        end
        if (got.irq !== want.irq) begin
          $error("irq expected %b actual %b", want.irq, got.irq);
          err_count++;
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    logic [1:0]       kind;
    logic [SEL_W-1:0] sel;
    logic [31:0]      wdata;
    logic [29:0]      levels;
    int pick;

    drive_word  = '0;
    oe_word     = '0;
    last_levels = '0;
    rise_events = '0;
    for (int g = 0; g < GROUPS; g++) group_enables[g] = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_beat(DIR_TAB[i].kind, DIR_TAB[i].sel, DIR_TAB[i].grp, DIR_TAB[i].wdata,
                DIR_TAB[i].levels, DIR_TAB[i].typed, DIR_TAB[i].res);
    end

    // Random reads, writes and samples
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) kind = KIND_READ;
      else if (pick < 65) kind = KIND_WRITE;
      else if (pick < 95) kind = KIND_SAMPLE;
      else kind = KIND_UNUSED;
      if ($urandom_range(0, 9) == 0) sel = 4'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI));
      else sel = 4'($urandom_range(REG_OUT, REG_IN));
      case ($urandom_range(0, 7))
        0: wdata = ALL_ONES;
        1: wdata = '0;
        default: wdata = $urandom;
      endcase
      // Mix fresh levels with single-pin toggles of the last sample
      if ($urandom_range(0, 1) == 0) levels = 30'($urandom);
      else levels = prev_levels ^ (30'd1 << $urandom_range(0, PINS - 1));
      if (kind == KIND_SAMPLE) prev_levels = levels;
      send_beat(kind, sel, 2'($urandom_range(0, 3)), wdata, levels, 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    // Drain, then let the pipeline settle
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("checked %0d result beats: %0d reads, %0d writes, %0d samples",
             n_checked, n_reads, n_writes, n_samples);
    $display("irq high on %0d results, %0d mismatches", n_irq_high, err_count);
    if (err_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

@@ gpio_bank_with_edge_interrupts_unit.f @@
+incdir+sv
sv/gbei_pkg.sv
sv/gpio_bank_with_edge_interrupts_unit.sv
bench/tb_top.sv
